@@ sv/gtmc_pkg.sv @@
`timescale 1ns / 1ps
package gtmc_pkg;

    localparam int MAX_LEN_DEF  = 16384;
    localparam int ALPHABET_DEF = 26;

    localparam int GAP_KINDS  = 3;
    localparam int GAP_FIRST  = 0;
    localparam int GAP_MIDDLE = 1;
    localparam int GAP_LAST   = 2;

    localparam int ENTRY_W    = 14;
    localparam int DIST_OUT_W = 11;
    localparam int LEN_OUT_W  = 15;

    localparam logic [ENTRY_W-1:0] COUNT_MAX = {ENTRY_W{1'b1}};
    localparam logic [7:0]         CHAR_A    = 8'h41;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_INIT_CLEAR,
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic drop;
        logic clear_step;
        logic update;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic len_full;
        logic clear_last;
        logic out_free;
    } stat_t;

endpackage

@@ sv/gtmc_ram.sv @@
`timescale 1ns / 1ps
module gtmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/gtmc_ctrl.sv @@
`timescale 1ns / 1ps
module gtmc_ctrl
    import gtmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] opcode,
    input  stat_t      stat,
    output logic       in_ready,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_INIT_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (opcode)
                        OP_START:
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        OP_ADD:
                        begin
                            if (stat.len_full)
                            begin
                                cmd.drop   = 1'b1;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_LOOKUP;
                            end
                        end
                        OP_READ:
                        begin
                            state_next = ST_LOOKUP;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/gtmc_datapath.sv @@
`timescale 1ns / 1ps
module gtmc_datapath
    import gtmc_pkg::*;
#(
    parameter int MAX_LEN  = MAX_LEN_DEF,
    parameter int ALPHABET = ALPHABET_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [1:0]            opcode,
    input  logic [7:0]            residue,
    input  logic [1:0]            gap_position,
    input  logic [4:0]            first_letter,
    input  logic [4:0]            second_letter,
    input  logic                  out_ready,
    output stat_t                 stat,
    output logic                  out_valid,
    output logic [ENTRY_W-1:0]    entry_count,
    output logic [DIST_OUT_W-1:0] distinct_patterns,
    output logic [LEN_OUT_W-1:0]  sequence_length,
    output logic                  overflow
);

    localparam int IDX_W  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int DEPTH  = ALPHABET * ALPHABET;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int DIST_W = $clog2(GAP_KINDS * DEPTH + 1);

    function automatic logic is_letter(input logic [7:0] ch);
        logic [7:0] diff;
        diff = ch - CHAR_A;
        return (ch >= CHAR_A) && ({1'b0, diff} < 9'(ALPHABET));
    endfunction

    function automatic logic [IDX_W-1:0] letter_idx(input logic [7:0] ch);
        logic [7:0] diff;
        diff = ch - CHAR_A;
        return diff[IDX_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot(input logic [IDX_W-1:0] i,
                                               input logic [IDX_W-1:0] j);
        return ADDR_W'(ADDR_W'(i) * ADDR_W'(ALPHABET) + ADDR_W'(j));
    endfunction

    logic [1:0]          op_reg;
    logic [7:0]          res_reg;
    logic [1:0]          gap_reg;
    logic [4:0]          l1_reg;
    logic [4:0]          l2_reg;
    logic [7:0]          older_reg;
    logic [7:0]          newer_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [DIST_W-1:0]   dist_next;
    logic [LEN_W-1:0]    len_reg;
    logic                ovf_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [ENTRY_W-1:0]  entry_reg;
    logic [ENTRY_W-1:0]  entry_next;

    logic                  out_valid_reg;
    logic [ENTRY_W-1:0]    out_entry_reg;
    logic [DIST_OUT_W-1:0] out_dist_reg;
    logic [LEN_OUT_W-1:0]  out_len_reg;
    logic                  out_ovf_reg;

    logic [7:0]         x_byte    [GAP_KINDS];
    logic [7:0]         y_byte    [GAP_KINDS];
    logic               hit       [GAP_KINDS];
    logic               zero_hit  [GAP_KINDS];
    logic               sat_hit   [GAP_KINDS];
    logic [ADDR_W-1:0]  bump_addr [GAP_KINDS];
    logic [ADDR_W-1:0]  raddr     [GAP_KINDS];
    logic [ADDR_W-1:0]  waddr     [GAP_KINDS];
    logic [ENTRY_W-1:0] wdata     [GAP_KINDS];
    logic [ENTRY_W-1:0] rdata     [GAP_KINDS];
    logic               we        [GAP_KINDS];

    logic              bump_en;
    logic              rd_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic              any_sat;

    assign x_byte[GAP_FIRST]  = newer_reg;
    assign y_byte[GAP_FIRST]  = res_reg;
    assign x_byte[GAP_MIDDLE] = older_reg;
    assign y_byte[GAP_MIDDLE] = res_reg;
    assign x_byte[GAP_LAST]   = older_reg;
    assign y_byte[GAP_LAST]   = newer_reg;

    assign bump_en = (op_reg == OP_ADD) && (len_reg >= LEN_W'(2));
    assign rd_ok   = (gap_reg < 2'(GAP_KINDS))
                  && ({1'b0, l1_reg} < 6'(ALPHABET))
                  && ({1'b0, l2_reg} < 6'(ALPHABET));
    assign rd_addr = slot(l1_reg[IDX_W-1:0], l2_reg[IDX_W-1:0]);

    for (genvar g = 0; g < GAP_KINDS; g++)
    begin : g_gap
        assign hit[g]       = bump_en && is_letter(x_byte[g]) && is_letter(y_byte[g]);
        assign bump_addr[g] = slot(letter_idx(x_byte[g]), letter_idx(y_byte[g]));
        assign zero_hit[g]  = hit[g] && (rdata[g] == '0);
        assign sat_hit[g]   = hit[g] && (rdata[g] == COUNT_MAX);
        assign raddr[g]     = (op_reg == OP_READ) ? rd_addr : bump_addr[g];
        assign we[g]        = cmd.clear_step || (cmd.update && hit[g] && !sat_hit[g]);
        assign waddr[g]     = cmd.clear_step ? clr_addr_reg : bump_addr[g];
        assign wdata[g]     = cmd.clear_step ? '0 : rdata[g] + ENTRY_W'(1);

        gtmc_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (DEPTH)
        ) u_count_ram (
            .clk   (clk),
            .we    (we[g]),
            .waddr (waddr[g]),
            .wdata (wdata[g]),
            .raddr (raddr[g]),
            .rdata (rdata[g])
        );
    end

    assign any_sat   = sat_hit[GAP_FIRST] || sat_hit[GAP_MIDDLE] || sat_hit[GAP_LAST];
    assign dist_next = dist_reg + DIST_W'(zero_hit[GAP_FIRST])
                     + DIST_W'(zero_hit[GAP_MIDDLE]) + DIST_W'(zero_hit[GAP_LAST]);

    always_comb
    begin
        entry_next = '0;
        if (rd_ok)
        begin
            case (gap_reg)
                2'(GAP_FIRST):  entry_next = rdata[GAP_FIRST];
                2'(GAP_MIDDLE): entry_next = rdata[GAP_MIDDLE];
                2'(GAP_LAST):   entry_next = rdata[GAP_LAST];
                default:        entry_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_reg <= residue;
            gap_reg <= gap_position;
            l1_reg  <= first_letter;
            l2_reg  <= second_letter;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg       <= '0;
            older_reg    <= '0;
            newer_reg    <= '0;
            dist_reg     <= '0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            clr_addr_reg <= '0;
            entry_reg    <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                op_reg    <= opcode;
                entry_reg <= '0;
            end
            if (cmd.start)
            begin
                older_reg <= '0;
                newer_reg <= '0;
                dist_reg  <= '0;
                len_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.drop)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= stat.clear_last ? '0 : clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.update)
            begin
                if (op_reg == OP_ADD)
                begin
                    dist_reg  <= dist_next;
                    older_reg <= newer_reg;
                    newer_reg <= res_reg;
                    len_reg   <= len_reg + LEN_W'(1);
                    if (any_sat)
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                else if (op_reg == OP_READ)
                begin
                    entry_reg <= entry_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_entry_reg <= entry_reg;
            out_dist_reg  <= DIST_OUT_W'(dist_reg);
            out_len_reg   <= LEN_OUT_W'(len_reg);
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign stat.len_full   = (len_reg >= LEN_W'(MAX_LEN));
    assign stat.clear_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid         = out_valid_reg;
    assign entry_count       = out_entry_reg;
    assign distinct_patterns = out_dist_reg;
    assign sequence_length   = out_len_reg;
    assign overflow          = out_ovf_reg;

endmodule

@@ sv/gapped_trimer_motif_counter_core.sv @@
`timescale 1ns / 1ps
// Gapped trimer motif counter. Each transfer on the input is one operation: start (clear
// all counts and the sequence), add one residue byte, or read the count of one pattern
// (*xy, x*y or xy*). Every operation returns one result with the entry count (reads only),
// the number of distinct patterns, the sequence length and the sticky overflow flag.
// Counts live in three RAMs of ALPHABET*ALPHABET words, one per gap position. An add or a
// read steps through accept, RAM read, update (the read-modify-write of an add) and result
// register; an unused opcode or a dropped residue goes from accept to the result register.
// A start runs a clear pass over all ALPHABET*ALPHABET addresses (676 by default) and then
// returns its result. The same clear pass runs after reset, during which no input transfer
// is taken. The result register frees the input side while a result waits for out_ready.
module gapped_trimer_motif_counter_core
    import gtmc_pkg::*;
#(
    parameter int MAX_LEN  = MAX_LEN_DEF,
    parameter int ALPHABET = ALPHABET_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [7:0]            residue,
    input  logic [1:0]            gap_position,
    input  logic [4:0]            first_letter,
    input  logic [4:0]            second_letter,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ENTRY_W-1:0]    entry_count,
    output logic [DIST_OUT_W-1:0] distinct_patterns,
    output logic [LEN_OUT_W-1:0]  sequence_length,
    output logic                  overflow
);

    cmd_t  cmd;
    stat_t stat;

    gtmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    gtmc_datapath #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .opcode            (opcode),
        .residue           (residue),
        .gap_position      (gap_position),
        .first_letter      (first_letter),
        .second_letter     (second_letter),
        .out_ready         (out_ready),
        .stat              (stat),
        .out_valid         (out_valid),
        .entry_count       (entry_count),
        .distinct_patterns (distinct_patterns),
        .sequence_length   (sequence_length),
        .overflow          (overflow)
    );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import gtmc_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 200_000;
    localparam int         DRAIN_WAIT  = 16;

    typedef struct packed {
        logic [ENTRY_W-1:0]    entry;
        logic [DIST_OUT_W-1:0] patterns;
        logic [LEN_OUT_W-1:0]  len;
        logic                  ovf;
    } motif_report_t;

    typedef struct packed {
        logic [1:0]    op;
        logic [7:0]    res;
        logic [1:0]    gap;
        logic [4:0]    l1;
        logic [4:0]    l2;
        logic          typed;
        motif_report_t want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            opcode;
    logic [7:0]            residue;
    logic [1:0]            gap_position;
    logic [4:0]            first_letter;
    logic [4:0]            second_letter;
    logic                  out_valid;
    logic                  out_ready;
    logic [ENTRY_W-1:0]    entry_count;
    logic [DIST_OUT_W-1:0] distinct_patterns;
    logic [LEN_OUT_W-1:0]  sequence_length;
    logic                  overflow;

    gapped_trimer_motif_counter_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .residue          (residue),
        .gap_position     (gap_position),
        .first_letter     (first_letter),
        .second_letter    (second_letter),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .entry_count      (entry_count),
        .distinct_patterns(distinct_patterns),
        .sequence_length  (sequence_length),
        .overflow         (overflow)
    );

    always #5 clk = ~clk;

    // motif table shadow
    logic [ENTRY_W-1:0] tally [GAP_KINDS][ALPHABET_DEF][ALPHABET_DEF];
    logic [7:0]         prev2;
    logic [7:0]         prev1;
    int unsigned        seen_patterns;
    int unsigned        seq_len;
    logic               sticky_ovf;

    motif_report_t      pending_reports[$];
    stim_row_t          directed_plan[$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int n_checked;
    int n_adds;
    int n_reads;
    int n_starts;
    int n_unused;
    int cycle_count;

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [1:0] rnd_gap();
        return 2'($urandom_range(3));
    endfunction

    function automatic logic [4:0] rnd_code();
        return 5'($urandom_range(31));
    endfunction

    function automatic void motif_model_clear();
        for (int g = 0; g < GAP_KINDS; g++)
            for (int i = 0; i < ALPHABET_DEF; i++)
                for (int j = 0; j < ALPHABET_DEF; j++)
                    tally[g][i][j] = '0;
        prev2         = '0;
        prev1         = '0;
        seen_patterns = 0;
        seq_len       = 0;
        sticky_ovf    = 1'b0;
    endfunction

    function automatic bit is_letter(input logic [7:0] ch);
        return (ch >= CHAR_A) && (int'(ch) < int'(CHAR_A) + ALPHABET_DEF);
    endfunction

    function automatic void bump_tally(input int g, input logic [7:0] x, input logic [7:0] y);
        int i;
        int j;
        if (!is_letter(x) || !is_letter(y))
            return;
        i = int'(x) - int'(CHAR_A);
        j = int'(y) - int'(CHAR_A);
        if (tally[g][i][j] == '0)
            seen_patterns++;
        if (tally[g][i][j] == COUNT_MAX)
            sticky_ovf = 1'b1;
        else
            tally[g][i][j] = tally[g][i][j] + ENTRY_W'(1);
    endfunction

    function automatic motif_report_t motif_model_step(input logic [1:0] op,
                                                       input logic [7:0] res,
                                                       input logic [1:0] gap,
                                                       input logic [4:0] l1,
                                                       input logic [4:0] l2);
        motif_report_t r;
        r.entry = '0;
        case (op)
            OP_START: motif_model_clear();
            OP_ADD: begin
                if (seq_len >= MAX_LEN_DEF) begin
                    sticky_ovf = 1'b1;
                end
                else begin
                    if (seq_len >= 2) begin
                        bump_tally(GAP_FIRST, prev1, res);
                        bump_tally(GAP_MIDDLE, prev2, res);
                        bump_tally(GAP_LAST, prev2, prev1);
                    end
                    prev2 = prev1;
                    prev1 = res;
                    seq_len++;
                end
            end
            OP_READ: begin
                if (gap < GAP_KINDS && l1 < ALPHABET_DEF && l2 < ALPHABET_DEF)
                    r.entry = tally[gap][l1][l2];
            end
            default: ;
        endcase
        r.patterns = seen_patterns[DIST_OUT_W-1:0];
        r.len      = seq_len[LEN_OUT_W-1:0];
        r.ovf      = sticky_ovf;
        return r;
    endfunction

    function automatic stim_row_t stim(input logic [1:0] op, input logic [7:0] res,
                                       input logic [1:0] gap, input logic [4:0] l1,
                                       input logic [4:0] l2, input logic typed,
                                       input int e_entry, input int e_dist,
                                       input int e_len, input int e_ovf);
        stim_row_t s;
        s.op            = op;
        s.res           = res;
        s.gap           = gap;
        s.l1            = l1;
        s.l2            = l2;
        s.typed         = typed;
        s.want.entry    = ENTRY_W'(e_entry);
        s.want.patterns = DIST_OUT_W'(e_dist);
        s.want.len      = LEN_OUT_W'(e_len);
        s.want.ovf      = 1'(e_ovf);
        return s;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    endtask

    task automatic issue_op(input logic [1:0] op, input logic [7:0] res,
                            input logic [1:0] gap, input logic [4:0] l1,
                            input logic [4:0] l2, input logic typed,
                            input motif_report_t typed_want);
        motif_report_t predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        residue       <= res;
        gap_position  <= gap;
        first_letter  <= l1;
        second_letter <= l2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = motif_model_step(op, res, gap, l1, l2);
        pending_reports.push_back(typed ? typed_want : predicted);
        case (op)
            OP_START: n_starts++;
            OP_ADD:   n_adds++;
            OP_READ:  n_reads++;
            default:  n_unused++;
        endcase
    endtask

    task automatic long_fill(input int n, input logic same_letter);
        logic [7:0] ch;
        issue_op(OP_START, rnd_byte(), rnd_gap(), rnd_code(), rnd_code(), 1'b0, '0);
        for (int k = 0; k < n; k++) begin
            ch = same_letter ? CHAR_A
                             : 8'(int'(CHAR_A) + $urandom_range(ALPHABET_DEF - 1));
            issue_op(OP_ADD, ch, rnd_gap(), rnd_code(), rnd_code(), 1'b0, '0);
        end
        for (int k = 0; k < 12; k++) begin
            if (same_letter)
                issue_op(OP_READ, rnd_byte(), 2'(k % GAP_KINDS), 5'd0, 5'd0, 1'b0, '0);
            else
                issue_op(OP_READ, rnd_byte(), 2'($urandom_range(GAP_KINDS - 1)),
                         5'($urandom_range(ALPHABET_DEF - 1)),
                         5'($urandom_range(ALPHABET_DEF - 1)), 1'b0, '0);
        end
    endtask

    task automatic random_phase(input int target);
        int done;
        int burst;
        int width;
        int base;
        int pick;
        done = 0;
        while (done < target) begin
            if ($urandom_range(1) == 0) begin
                issue_op(OP_START, rnd_byte(), rnd_gap(), rnd_code(), rnd_code(), 1'b0, '0);
                done++;
            end
            burst = $urandom_range(3, 40);
            width = $urandom_range(1, ALPHABET_DEF);
            base  = $urandom_range(0, ALPHABET_DEF - width);
            repeat (burst) begin
                pick = $urandom_range(99);
                if (pick < 68) begin
                    issue_op(OP_ADD, 8'(int'(CHAR_A) + base + $urandom_range(width - 1)),
                             rnd_gap(), rnd_code(), rnd_code(), 1'b0, '0);
                    done++;
                end
                else if (pick < 78) begin
                    issue_op(OP_ADD, rnd_byte(), rnd_gap(), rnd_code(), rnd_code(), 1'b0, '0);
                    done++;
                end
                else if (pick < 92) begin
                    issue_op(OP_READ, rnd_byte(), 2'($urandom_range(GAP_KINDS - 1)),
                             5'(base + $urandom_range(width - 1)),
                             5'(base + $urandom_range(width - 1)), 1'b0, '0);
                    done++;
                end
                else if (pick < 97) begin
                    issue_op(OP_READ, rnd_byte(), rnd_gap(), rnd_code(), rnd_code(), 1'b0, '0);
                    done++;
                end
                else begin
                    issue_op(OP_UNUSED, rnd_byte(), rnd_gap(), rnd_code(), rnd_code(),
                             1'b0, '0);
                end
            end
        end
    endtask

    always @(posedge clk) begin
        motif_report_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("result with no transfer pending", int'(entry_count), 0);
            end
            else begin
                want = pending_reports.pop_front();
                n_checked++;
                if (entry_count !== want.entry)
                    flag_mismatch("entry_count", int'(entry_count), int'(want.entry));
                if (distinct_patterns !== want.patterns)
                    flag_mismatch("distinct_patterns", int'(distinct_patterns),
                                  int'(want.patterns));
                if (sequence_length !== want.len)
                    flag_mismatch("sequence_length", int'(sequence_length), int'(want.len));
                if (overflow !== want.ovf)
                    flag_mismatch("overflow", int'(overflow), int'(want.ovf));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout at cycle %0d with %0d results outstanding",
                     cycle_count, pending_reports.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        stim_row_t row;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_START;
        residue        = '0;
        gap_position   = '0;
        first_letter   = '0;
        second_letter  = '0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        n_checked      = 0;
        n_adds         = 0;
        n_reads        = 0;
        n_starts       = 0;
        n_unused       = 0;
        cycle_count    = 0;
        motif_model_clear();

        directed_plan.push_back(stim(OP_READ, 8'h00, GAP_FIRST, 0, 0, 1, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_ADD, CHAR_A, 0, 0, 0, 1, 0, 0, 1, 0));
        directed_plan.push_back(stim(OP_ADD, CHAR_A + 8'd1, 0, 0, 0, 1, 0, 0, 2, 0));
        directed_plan.push_back(stim(OP_ADD, CHAR_A + 8'd2, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_READ, 8'h00, GAP_FIRST, 1, 2, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_READ, 8'h00, GAP_MIDDLE, 0, 2, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_READ, 8'h00, GAP_LAST, 0, 1, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_ADD, 8'h5A, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_ADD, 8'h61, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_ADD, 8'h40, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_ADD, 8'h5B, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_ADD, 8'hFF, 2'd3, 5'd31, 5'd31, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_ADD, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_READ, 8'h00, GAP_KINDS, 0, 0, 1, 0, 7, 9, 0));
        directed_plan.push_back(stim(OP_READ, 8'h00, GAP_LAST, 5'd31, 0, 1, 0, 7, 9, 0));
        directed_plan.push_back(stim(OP_READ, 8'h00, GAP_LAST, 0, 5'd31, 1, 0, 7, 9, 0));
        directed_plan.push_back(stim(OP_READ, 8'hFF, GAP_LAST, 2, 25, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_READ, 8'h00, GAP_FIRST, 25, 25, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_UNUSED, 8'hFF, 2'd3, 5'd31, 5'd31, 1, 0, 7, 9, 0));
        directed_plan.push_back(stim(OP_START, 8'hFF, 2'd3, 5'd31, 5'd31, 1, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_ADD, 8'h5A, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_ADD, 8'h5A, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_ADD, 8'h5A, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_plan.push_back(stim(OP_READ, 8'h00, GAP_MIDDLE, 25, 25, 0, 0, 0, 0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[k]) begin
            row = directed_plan[k];
            issue_op(row.op, row.res, row.gap, row.l1, row.l2, row.typed, row.want);
        end

        // mixed-letter fill, then a run of one letter
        long_fill(150, 1'b0);
        long_fill(40, 1'b1);

        random_phase(160);
        send_idle_pct  = 65;
        recv_stall_pct = 0;
        random_phase(160);
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        random_phase(160);
        send_idle_pct  = 34;
        recv_stall_pct = 34;
        random_phase(160);

        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d transfers: %0d adds, %0d reads, %0d starts, %0d unused opcodes",
                 n_adds + n_reads + n_starts + n_unused, n_adds, n_reads, n_starts, n_unused);
        $display("Checked %0d results over four idle/stall mixes, %0d mismatches",
                 n_checked, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
sv/gtmc_pkg.sv
sv/gtmc_ram.sv
sv/gtmc_ctrl.sv
sv/gtmc_datapath.sv
sv/gapped_trimer_motif_counter_core.sv
bench/testbench.sv
